[src/assert_macros.svh]
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, held off while reset is high.
`define IOLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("list engine check failed");
// Clocked check that also holds through reset.
`define IOLE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("list engine check failed");
`else
`define IOLE_ASSERT(lbl, prop)
`define IOLE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[src/iole_pkg.sv]
// Shared types and constants of the indexed ordered list engine.
package iole_pkg;

  localparam int DATA_W     = 32;
  localparam int FUNC_W     = 3;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 7;
  localparam int CAPACITY_D = 64;

  typedef enum logic [FUNC_W-1:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_AT     = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command seen by every cell of the row.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_op_t;

endpackage

[src/iole_cmd_if.sv]
// Request channel of the list engine: command, position and value.
interface iole_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [iole_pkg::FUNC_W-1:0]      func;
  logic [iole_pkg::POS_W-1:0]       position;
  logic signed [iole_pkg::DATA_W-1:0] item_value;

  modport source (output valid, output func, output position, output item_value,
                  input ready);
  modport sink   (input valid, input func, input position, input item_value,
                  output ready);
endinterface

[src/iole_res_if.sv]
// Result channel of the list engine: read value, status and list length.
interface iole_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [iole_pkg::DATA_W-1:0] read_value;
  logic [iole_pkg::STATUS_W-1:0]      status;
  logic [iole_pkg::LEN_W-1:0]         length;

  modport source (output valid, output read_value, output status, output length,
                  input ready);
  modport sink   (input valid, input read_value, input status, input length,
                  output ready);
endinterface

[src/indexed_ordered_list_engine.sv]
// Top level of the indexed ordered list engine: control, result register, row of cells.
//
// A request is accepted in the idle state; in the execute state that follows, every
// cell of the row shifts, loads or holds at once and the result register is written.
// A new request is taken only once the engine is back in idle and the result register
// is empty or being drained, so requests never overlap. The row has CAPACITY cells;
// positions are seven bits, so with CAPACITY above 128 only the first 128 entries are
// addressable by read, insert at position and delete. Reset clears the count, the state
// and the result valid flag; entry contents stay undefined until inserted.
`include "assert_macros.svh"

module indexed_ordered_list_engine #(
  parameter int CAPACITY = iole_pkg::CAPACITY_D
) (
  input  logic       clk,
  input  logic       rst,
  iole_cmd_if.sink   cmd,
  iole_res_if.source res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > iole_pkg::POS_W) ? CW : iole_pkg::POS_W;
  localparam int DW = iole_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovalid;

  logic [iole_pkg::FUNC_W-1:0]  c_func;
  logic [iole_pkg::POS_W-1:0]   c_pos;
  logic [DW-1:0]                c_val;

  logic [DW-1:0]                rd_value;
  logic [DW-1:0]                rd_next;
  iole_pkg::status_t            st;
  iole_pkg::status_t            st_next;
  logic [iole_pkg::LEN_W-1:0]   len;

  iole_pkg::cell_op_t           op;
  logic [PW-1:0]                cell_pos;
  logic [PW-1:0]                pos_p;
  logic [PW-1:0]                cnt_p;
  logic                         full;
  logic                         accept;

  logic [DW-1:0] data [CAPACITY];
  logic [DW-1:0] taps [CAPACITY];
  logic [DW-1:0] tap_or;

  assign cmd.ready = (state == S_IDLE) && (!ovalid || res.ready);
  assign accept    = cmd.valid && cmd.ready;

  assign res.valid      = ovalid;
  assign res.read_value = rd_value;
  assign res.status     = st;
  assign res.length     = len;

  always_ff @(posedge clk) begin
    if (accept) begin
      c_func <= cmd.func;
      c_pos  <= cmd.position;
      c_val  <= cmd.item_value;
    end
  end

  // Read bus: only the addressed cell drives a non-zero tap.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  assign pos_p = PW'(c_pos);
  assign cnt_p = PW'(count);
  assign full  = (count == CW'(CAPACITY));

  always_comb begin
    op         = '0;
    cell_pos   = pos_p;
    rd_next    = '0;
    st_next    = iole_pkg::ST_DONE;
    count_next = count;
    case (c_func)
      iole_pkg::OP_READ: begin
        if (pos_p < cnt_p) begin
          rd_next = tap_or;
        end else begin
          rd_next = '1;
          st_next = iole_pkg::ST_RANGE;
        end
      end
      iole_pkg::OP_HEAD: begin
        if (full) begin
          st_next = iole_pkg::ST_FULL;
        end else begin
          op.ins     = 1'b1;
          cell_pos   = '0;
          count_next = count + CW'(1);
        end
      end
      iole_pkg::OP_TAIL: begin
        if (full) begin
          st_next = iole_pkg::ST_FULL;
        end else begin
          op.ins     = 1'b1;
          cell_pos   = cnt_p;
          count_next = count + CW'(1);
        end
      end
      iole_pkg::OP_AT: begin
        if (pos_p > cnt_p) begin
          st_next = iole_pkg::ST_RANGE;
        end else if (full) begin
          st_next = iole_pkg::ST_FULL;
        end else begin
          op.ins     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      iole_pkg::OP_DELETE: begin
        if (pos_p >= cnt_p) begin
          st_next = iole_pkg::ST_RANGE;
        end else begin
          op.del     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (state != S_EXEC) begin
      op = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count  <= count_next;
          ovalid <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      rd_value <= rd_next;
      st       <= st_next;
      len      <= iole_pkg::LEN_W'(count_next);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left;
    logic [DW-1:0] right;
    if (g == 0) begin : g_first
      assign left = c_val;
    end else begin : g_mid
      assign left = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = data[g];
    end else begin : g_inner
      assign right = data[g+1];
    end
    iole_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk   (clk),
      .op    (op),
      .pos   (cell_pos),
      .value (c_val),
      .left  (left),
      .right (right),
      .data  (data[g]),
      .tap   (taps[g])
    );
  end

  `IOLE_ASSERT(a_count_bound, count <= CW'(CAPACITY))
  `IOLE_ASSERT(a_count_in_exec, (count != $past(count)) |-> $past(state == S_EXEC))
  `IOLE_ASSERT(a_len_tracks, res.valid |-> (res.length == iole_pkg::LEN_W'(count)))
  `IOLE_ASSERT(a_full_flag, (res.valid && res.status == iole_pkg::ST_FULL) |-> full)
  `IOLE_ASSERT(a_result_from_exec, $rose(ovalid) |-> $past(state == S_EXEC))

endmodule

[src/iole_cell.sv]
// One list slot: holds an entry and shifts with its neighbours.
module iole_cell #(
  parameter int IDX = 0,
  parameter int PW  = iole_pkg::POS_W
) (
  input  logic                        clk,
  input  iole_pkg::cell_op_t          op,
  input  logic [PW-1:0]               pos,
  input  logic [iole_pkg::DATA_W-1:0] value,
  input  logic [iole_pkg::DATA_W-1:0] left,
  input  logic [iole_pkg::DATA_W-1:0] right,
  output logic [iole_pkg::DATA_W-1:0] data,
  output logic [iole_pkg::DATA_W-1:0] tap
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic at;
  logic above;

  assign at    = (pos == MY_IDX);
  assign above = (MY_IDX > pos);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (at) begin
        data <= value;
      end else if (above) begin
        data <= left;
      end
    end else if (op.del && (at || above)) begin
      data <= right;
    end
  end

  assign tap = at ? data : '0;

endmodule

[verif/indexed_ordered_list_engine_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the list engine: directed table, full list, then random requests.
module indexed_ordered_list_engine_tb;

  localparam int LIMIT_CYCLES = 300000;
  localparam int PLAN_N       = 25;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 118;

  localparam logic [iole_pkg::FUNC_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [iole_pkg::FUNC_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [iole_pkg::FUNC_W-1:0] OP_SPARE7 = 3'd7;
  localparam logic [iole_pkg::DATA_W-1:0] RD_INVALID = '1;
  localparam logic [iole_pkg::DATA_W-1:0] V_MAX      = 32'h7fff_ffff;
  localparam logic [iole_pkg::DATA_W-1:0] V_MIN      = 32'h8000_0000;

  typedef struct packed {
    logic signed [iole_pkg::DATA_W-1:0] read_value;
    iole_pkg::status_t                  status;
    logic [iole_pkg::LEN_W-1:0]         length;
  } list_result_t;

  typedef struct packed {
    logic [iole_pkg::FUNC_W-1:0] func;
    logic [iole_pkg::POS_W-1:0]  pos;
    logic [iole_pkg::DATA_W-1:0] value;
    logic                        typed;
    logic [iole_pkg::DATA_W-1:0] rd;
    iole_pkg::status_t           st;
    logic [iole_pkg::LEN_W-1:0]  len;
  } plan_row_t;

  logic clk;
  logic rst;

  iole_cmd_if cmd_ch();
  iole_res_if res_ch();

  indexed_ordered_list_engine uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  logic signed [iole_pkg::DATA_W-1:0] list_vals [iole_pkg::CAPACITY_D];
  int unsigned              list_len;
  list_result_t             pending_results [$];
  list_result_t             want;
  plan_row_t                plan [PLAN_N];
  int                       err_cnt;
  int                       cycle_cnt;
  int                       stim_phase;
  int                       send_idle_pct;
  int                       recv_idle_pct;
  int                       hold_left;
  bit                       hold_done;
  bit                       growing;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one request to the shadow list and returns what the engine should answer.
  function automatic list_result_t list_apply(input logic [iole_pkg::FUNC_W-1:0] f,
                                              input logic [iole_pkg::POS_W-1:0] p,
                                              input logic [iole_pkg::DATA_W-1:0] v);
    list_result_t r;
    bit           full;
    int           at;
    r = '{read_value: '0, status: iole_pkg::ST_DONE, length: '0};
    full = (list_len >= iole_pkg::CAPACITY_D);
    at = -1;
    case (f)
      iole_pkg::OP_READ: begin
        if (p < list_len) r.read_value = list_vals[p];
        else begin
          r.read_value = RD_INVALID;
          r.status = iole_pkg::ST_RANGE;
        end
      end
      iole_pkg::OP_HEAD: begin
        if (full) r.status = iole_pkg::ST_FULL;
        else at = 0;
      end
      iole_pkg::OP_TAIL: begin
        if (full) r.status = iole_pkg::ST_FULL;
        else at = list_len;
      end
      iole_pkg::OP_AT: begin
        if (p > list_len) r.status = iole_pkg::ST_RANGE;
        else if (full) r.status = iole_pkg::ST_FULL;
        else at = p;
      end
      iole_pkg::OP_DELETE: begin
        if (p >= list_len) r.status = iole_pkg::ST_RANGE;
        else begin
          for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
        end
      end
      default: ;
    endcase
    if (at >= 0) begin
      for (int i = list_len; i > at; i--) list_vals[i] = list_vals[i - 1];
      list_vals[at] = v;
      list_len++;
    end
    r.length = list_len[iole_pkg::LEN_W-1:0];
    return r;
  endfunction

  // Offers one request, with random gaps ahead of it, and records its expected answer.
  task automatic send_cmd(input logic [iole_pkg::FUNC_W-1:0] f,
                          input logic [iole_pkg::POS_W-1:0] p,
                          input logic [iole_pkg::DATA_W-1:0] v, input bit use_typed,
                          input list_result_t typed_res, output list_result_t got);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.func       <= f;
    cmd_ch.position   <= p;
    cmd_ch.item_value <= v;
    do @(posedge clk); while (!cmd_ch.ready);
    got = list_apply(f, p, v);
    pending_results.push_back(use_typed ? typed_res : got);
  endtask

  task automatic drain;
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_requests(input int n);
    int                          sent;
    int                          roll;
    logic [iole_pkg::FUNC_W-1:0] f;
    logic [iole_pkg::POS_W-1:0]  p;
    logic [iole_pkg::DATA_W-1:0] v;
    list_result_t                r;
    sent = 0;
    while (sent < n) begin
      if (list_len == 0) growing = 1'b1;
      else if (list_len >= iole_pkg::CAPACITY_D && $urandom_range(9) == 0) growing = 1'b0;
      else if ($urandom_range(99) < 2) growing = ~growing;
      roll = $urandom_range(99);
      if (roll < 25) f = iole_pkg::OP_READ;
      else if (roll < (growing ? 85 : 40)) begin
        case ($urandom_range(2))
          0: f = iole_pkg::OP_HEAD;
          1: f = iole_pkg::OP_TAIL;
          default: f = iole_pkg::OP_AT;
        endcase
      end else f = iole_pkg::OP_DELETE;
      if (f == iole_pkg::OP_AT) p = iole_pkg::POS_W'($urandom_range(list_len));
      else p = (list_len > 0) ? iole_pkg::POS_W'($urandom_range(list_len - 1)) : '0;
      // noise: stray positions and spare codes
      if ($urandom_range(99) < 8) p = iole_pkg::POS_W'($urandom_range(127));
      if ($urandom_range(99) < 4) f = iole_pkg::FUNC_W'($urandom_range(7));
      case ($urandom_range(19))
        0: v = V_MAX;
        1: v = V_MIN;
        2: v = '0;
        3: v = RD_INVALID;
        default: v = $urandom;
      endcase
      send_cmd(f, p, v, 1'b0, '0, r);
      sent++;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [iole_pkg::DATA_W-1:0] want_v,
                               input logic [iole_pkg::DATA_W-1:0] got_v);
    err_cnt++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no request pending, got %h %h %h", $time,
                 res_ch.read_value, res_ch.status, res_ch.length);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.read_value !== want.read_value)
          flag_mismatch("read_value", want.read_value, res_ch.read_value);
        if (res_ch.status !== want.status)
          flag_mismatch("status", iole_pkg::DATA_W'(want.status),
                        iole_pkg::DATA_W'(res_ch.status));
        if (res_ch.length !== want.length)
          flag_mismatch("length", iole_pkg::DATA_W'(want.length),
                        iole_pkg::DATA_W'(res_ch.length));
      end
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) res_ch.ready <= 1'b0;
      else if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (stim_phase == 2 && !hold_done) begin
        res_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    list_result_t r;
    list_result_t typed_res;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.func       <= '0;
    cmd_ch.position   <= '0;
    cmd_ch.item_value <= '0;
    rst               <= 1'b1;
    list_len  = 0;
    growing   = 1'b1;
    stim_phase    = 0;
    send_idle_pct = 17;
    recv_idle_pct = 59;
    plan = '{
      '{iole_pkg::OP_READ,   7'd0,   32'd0,      1'b1, RD_INVALID, iole_pkg::ST_RANGE, 7'd0},
      '{iole_pkg::OP_DELETE, 7'd0,   32'd0,      1'b1, 32'd0,      iole_pkg::ST_RANGE, 7'd0},
      '{iole_pkg::OP_AT,     7'd1,   32'd9,      1'b1, 32'd0,      iole_pkg::ST_RANGE, 7'd0},
      '{iole_pkg::OP_AT,     7'd127, 32'd9,      1'b1, 32'd0,      iole_pkg::ST_RANGE, 7'd0},
      '{iole_pkg::OP_HEAD,   7'd0,   V_MAX,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd1},
      '{iole_pkg::OP_TAIL,   7'd127, V_MIN,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd2},
      '{iole_pkg::OP_AT,     7'd1,   32'd0,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd3},
      '{iole_pkg::OP_AT,     7'd3,   RD_INVALID, 1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd4},
      '{iole_pkg::OP_READ,   7'd0,   RD_INVALID, 1'b1, V_MAX,      iole_pkg::ST_DONE,  7'd4},
      '{iole_pkg::OP_READ,   7'd1,   32'd0,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd4},
      '{iole_pkg::OP_READ,   7'd2,   32'd0,      1'b1, V_MIN,      iole_pkg::ST_DONE,  7'd4},
      '{iole_pkg::OP_READ,   7'd3,   32'd0,      1'b1, RD_INVALID, iole_pkg::ST_DONE,  7'd4},
      '{iole_pkg::OP_READ,   7'd4,   32'd0,      1'b1, RD_INVALID, iole_pkg::ST_RANGE, 7'd4},
      '{iole_pkg::OP_READ,   7'd127, 32'd0,      1'b1, RD_INVALID, iole_pkg::ST_RANGE, 7'd4},
      '{OP_SPARE5,           7'd127, RD_INVALID, 1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd4},
      '{OP_SPARE6,           7'd0,   V_MAX,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd4},
      '{OP_SPARE7,           7'd1,   V_MIN,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd4},
      '{iole_pkg::OP_DELETE, 7'd4,   32'd0,      1'b1, 32'd0,      iole_pkg::ST_RANGE, 7'd4},
      '{iole_pkg::OP_DELETE, 7'd0,   32'd0,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd3},
      '{iole_pkg::OP_DELETE, 7'd2,   32'd0,      1'b1, 32'd0,      iole_pkg::ST_DONE,  7'd2},
      '{iole_pkg::OP_AT,     7'd0,   32'h5555_5555, 1'b1, 32'd0,   iole_pkg::ST_DONE,  7'd3},
      '{iole_pkg::OP_READ,   7'd0,   32'd0,      1'b0, 32'd0,      iole_pkg::ST_DONE,  7'd0},
      '{iole_pkg::OP_AT,     7'd127, 32'h1234_5678, 1'b1, 32'd0,   iole_pkg::ST_RANGE, 7'd3},
      '{iole_pkg::OP_HEAD,   7'd0,   32'haaaa_aaaa, 1'b0, 32'd0,   iole_pkg::ST_DONE,  7'd0},
      '{iole_pkg::OP_READ,   7'd1,   32'd0,      1'b0, 32'd0,      iole_pkg::ST_DONE,  7'd0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      typed_res = '{read_value: plan[i].rd, status: plan[i].st, length: plan[i].len};
      send_cmd(plan[i].func, plan[i].pos, plan[i].value, plan[i].typed, typed_res, r);
    end

    // fill to capacity, then hit every insert against the full list
    while (list_len < iole_pkg::CAPACITY_D)
      send_cmd(iole_pkg::OP_TAIL, iole_pkg::POS_W'($urandom_range(127)), $urandom,
               1'b0, '0, r);
    send_cmd(iole_pkg::OP_HEAD, 7'd0, V_MAX, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_TAIL, 7'd0, V_MIN, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_AT, iole_pkg::POS_W'(list_len), 32'd1, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_AT, iole_pkg::POS_W'(list_len + 1), 32'd2, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_AT, 7'd0, 32'd3, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_READ, iole_pkg::POS_W'(list_len - 1), 32'd0, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_READ, iole_pkg::POS_W'(list_len), 32'd0, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_DELETE, iole_pkg::POS_W'(list_len - 1), 32'd0, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_AT, iole_pkg::POS_W'(list_len), V_MIN, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_DELETE, 7'd0, 32'd0, 1'b0, '0, r);
    send_cmd(iole_pkg::OP_HEAD, 7'd0, RD_INVALID, 1'b0, '0, r);
    drain();

    random_requests(PHASE_ITEMS);
    drain();

    stim_phase    = 1;
    send_idle_pct = 59;
    recv_idle_pct = 17;
    random_requests(PHASE_ITEMS);
    drain();

    stim_phase    = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(PHASE_ITEMS);
    drain();

    repeat (8) @(posedge clk);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/iole_pkg.sv
src/iole_cmd_if.sv
src/iole_res_if.sv
src/iole_cell.sv
src/indexed_ordered_list_engine.sv
verif/indexed_ordered_list_engine_tb.sv
